>>> hw/rtl/bns_pkg.sv
// Package for the buzzer note sequencer: sizes, codes, and the word types.
// Used by every file of the block but bns_ram; depends on nothing else.
`default_nettype none

package bns_pkg;

    // Note table depth and the widths that follow from it.
    localparam int NOTE_DEPTH = 64;
    localparam int ADDR_W     = $clog2(NOTE_DEPTH);
    localparam int POS_W      = ADDR_W + 1;
    localparam int IDX_W      = 6;
    localparam int FREQ_W     = 16;
    localparam int MS_W       = 16;
    localparam int ENTRY_W    = FREQ_W + MS_W;

    // Position value that marks the end of the table.
    localparam logic [POS_W-1:0] POS_END = POS_W'(NOTE_DEPTH);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULATE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_FREQ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_NOTE_MS  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [FREQ_W-1:0] DEFAULT_FREQ_RST = 16'd2000;
    localparam logic [MS_W-1:0]   MAX_NOTE_MS_RST  = 16'd10000;

    // Special note frequencies.
    localparam logic [FREQ_W-1:0] FREQ_SILENT  = 16'd0;
    localparam logic [FREQ_W-1:0] FREQ_DEFAULT = 16'd1;

    // Item modes; the two unused codes fall to a default arm.
    typedef enum logic [2:0] {
        MODE_TICK  = 3'd0,
        MODE_WRITE = 3'd1,
        MODE_PLAY  = 3'd2,
        MODE_BEEP  = 3'd3,
        MODE_STOP  = 3'd4,
        MODE_CLICK = 3'd5
    } t_mode;

    // Pin drive kinds.
    typedef enum logic [1:0] {
        DRIVE_LOW  = 2'd0,
        DRIVE_TONE = 2'd1,
        DRIVE_HIGH = 2'd2
    } t_drive;

    // Controller states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EVAL = 1'b1
    } t_ctl_state;

    // One input word.
    typedef struct packed {
        logic [2:0]        mode;
        logic [IDX_W-1:0]  note_index;
        logic [FREQ_W-1:0] note_freq;
        logic [MS_W-1:0]   note_ms;
        logic [MS_W-1:0]   beep_ms;
        logic [FREQ_W-1:0] beep_freq;
    } t_item;

    // One result word.
    typedef struct packed {
        logic [1:0]        drive_kind;
        logic [FREQ_W-1:0] tone_freq;
        logic              busy_res;
        logic              playing;
        logic              click_pulse;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic eval;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fetch;
        logic room;
    } t_dp_status;

endpackage

`default_nettype wire

>>> hw/rtl/bns_in_if.sv
// Input channel of the buzzer note sequencer: valid, ready and one input word.
// Depends on bns_pkg for the field widths.
`default_nettype none

interface bns_in_if
    import bns_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [2:0]        mode;
    logic [IDX_W-1:0]  note_index;
    logic [FREQ_W-1:0] note_freq;
    logic [MS_W-1:0]   note_ms;
    logic [MS_W-1:0]   beep_ms;
    logic [FREQ_W-1:0] beep_freq;

    modport source (
        output valid, mode, note_index, note_freq, note_ms, beep_ms, beep_freq,
        input  ready
    );
    modport sink (
        input  valid, mode, note_index, note_freq, note_ms, beep_ms, beep_freq,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/bns_out_if.sv
// Output channel of the buzzer note sequencer: valid, ready and one result word.
// Depends on bns_pkg for the field widths.
`default_nettype none

interface bns_out_if
    import bns_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        drive_kind;
    logic [FREQ_W-1:0] tone_freq;
    logic              busy_res;
    logic              playing;
    logic              click_pulse;

    modport source (
        output valid, drive_kind, tone_freq, busy_res, playing, click_pulse,
        input  ready
    );
    modport sink (
        input  valid, drive_kind, tone_freq, busy_res, playing, click_pulse,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/buzzer_note_sequencer_top.sv
// Top level of the buzzer note sequencer.
// Depends on bns_pkg, bns_in_if, bns_out_if, bns_ctl and bns_dp.
`default_nettype none

// Each input word yields one result word. Ticks that do not end a note, note writes,
// beeps, stops, clicks and plays from an invalid index are applied in the cycle they
// are taken; a play from a valid index, and a tick that moves a running playlist to
// its next note, also pass through the EVAL state, waiting on the registered read
// port of the 64-entry note table. One word is in work at a time. Results wait in a
// two-word queue, so a new word is taken while an earlier result is still unread.
// The note table has no reset: play only entries that were written. Configuration
// writes are taken at any cycle and must be made while the block is idle.
module buzzer_note_sequencer_top
    import bns_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [FREQ_W-1:0]    i_cfg_data,
    bns_in_if.sink                    i_in,
    bns_out_if.source                 o_out
);

    t_item      w_item;
    t_result    w_res;
    t_ctl_cmd   w_cmd;
    t_dp_status w_status;
    logic       w_out_valid;

    // Gather the input word.
    always_comb begin
        w_item.mode       = i_in.mode;
        w_item.note_index = i_in.note_index;
        w_item.note_freq  = i_in.note_freq;
        w_item.note_ms    = i_in.note_ms;
        w_item.beep_ms    = i_in.beep_ms;
        w_item.beep_freq  = i_in.beep_freq;
    end

    bns_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    bns_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (w_item),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_out       (w_res)
    );

    // Present the result word.
    assign o_out.valid       = w_out_valid;
    assign o_out.drive_kind  = w_res.drive_kind;
    assign o_out.tone_freq   = w_res.tone_freq;
    assign o_out.busy_res    = w_res.busy_res;
    assign o_out.playing     = w_res.playing;
    assign o_out.click_pulse = w_res.click_pulse;

`ifndef SYNTHESIS
    // A click pulse is only granted while the buzzer is quiet.
    a_click_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.click_pulse && o_out.busy_res))
        else $error("click pulse granted while busy");

    // A tone frequency is reported only with a square-wave drive.
    a_freq_tone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.drive_kind != DRIVE_TONE)) |-> (o_out.tone_freq == '0))
        else $error("tone frequency without tone drive");

    // A word that needs a table read is evaluated in the next cycle.
    a_fetch_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.take && w_status.fetch) |=> (w_cmd.eval && !i_in.ready))
        else $error("table read not followed by evaluation");

    // A running playlist always reports busy.
    a_play_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.playing) |-> o_out.busy_res)
        else $error("playing without busy");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/bns_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the note table.
`default_nettype none

module bns_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/bns_ctl.sv
// Controller of the buzzer note sequencer: takes input words and steps
// through a table lookup when one is needed. Depends on bns_pkg.
`default_nettype none

module bns_ctl
    import bns_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_ctl_cmd        o_cmd
);

    t_ctl_state r_state;
    t_ctl_state n_state;
    logic       w_take;

    assign w_take = (r_state == ST_IDLE) && i_in_valid && i_status.room;

    // Next state: a word that reads the note table goes through EVAL before IDLE again.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take && i_status.fetch) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs of the controller.
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = i_status.room;
                o_cmd.take = w_take;
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bns_dp.sv
// Datapath of the buzzer note sequencer: configuration registers, note table,
// timer and drive state, and a two-word result queue. Depends on bns_pkg, bns_ram.
`default_nettype none

module bns_dp
    import bns_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [FREQ_W-1:0]    i_cfg_data,
    input  wire t_item                i_item,
    input  wire t_ctl_cmd             i_cmd,
    output t_dp_status                o_status,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_result                   o_out
);

    // Configuration registers.
    logic              r_modulate;
    logic [FREQ_W-1:0] r_default_freq;
    logic [MS_W-1:0]   r_max_note_ms;

    // Sequencer state.
    logic [MS_W-1:0]   r_rem;
    logic [POS_W-1:0]  r_pos;
    logic              r_armed;
    logic              r_busy;
    logic              r_playing;
    t_drive            r_drive;
    logic [FREQ_W-1:0] r_freq;

    logic [MS_W-1:0]   n_rem;
    logic [POS_W-1:0]  n_pos;
    logic              n_armed;
    logic              n_busy;
    logic              n_playing;
    t_drive            n_drive;
    logic [FREQ_W-1:0] n_freq;
    logic              n_pulse;

    // Result queue: slot 0 is presented on the output.
    t_result           r_slot0;
    t_result           r_slot1;
    logic [1:0]        r_cnt;
    logic [1:0]        w_left;
    logic              w_push;
    logic              w_pop;
    t_result           w_res;

    // Note table signals.
    logic              w_ram_we;
    logic [ADDR_W-1:0] w_raddr;
    logic [ENTRY_W-1:0] w_rdata;
    logic [FREQ_W-1:0] w_tab_freq;
    logic [MS_W-1:0]   w_tab_ms;

    logic [MS_W-1:0]   w_dec;
    logic              w_idx_ok;
    logic              w_pos_ok;
    logic              w_fires;

    assign w_dec    = (r_rem != '0) ? (r_rem - 1'b1) : '0;
    assign w_idx_ok = (32'(i_item.note_index) < 32'(NOTE_DEPTH));
    assign w_pos_ok = (r_pos < POS_END);
    assign w_fires  = r_armed && (w_dec == '0);

    // A play from a valid index, or a tick that ends a note of a running
    // playlist before the table end, needs a table read.
    always_comb begin
        o_status.fetch = 1'b0;
        o_status.room  = (r_cnt != 2'd2);
        if (i_item.mode == MODE_PLAY) begin
            o_status.fetch = w_idx_ok;
        end else if (i_item.mode == MODE_TICK) begin
            o_status.fetch = w_fires && r_playing && w_pos_ok;
        end
    end

    // Note table: frequency in the upper half, duration in the lower half.
    assign w_ram_we   = i_cmd.take && (i_item.mode == MODE_WRITE) && w_idx_ok;
    assign w_raddr    = (i_item.mode == MODE_PLAY) ? ADDR_W'(i_item.note_index)
                                                   : r_pos[ADDR_W-1:0];
    assign w_tab_freq = w_rdata[ENTRY_W-1:MS_W];
    assign w_tab_ms   = w_rdata[MS_W-1:0];

    bns_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NOTE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (ADDR_W'(i_item.note_index)),
        .i_wdata ({i_item.note_freq, i_item.note_ms}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Next sequencer state for a taken word or for the table evaluation.
    always_comb begin
        n_rem     = r_rem;
        n_pos     = r_pos;
        n_armed   = r_armed;
        n_busy    = r_busy;
        n_playing = r_playing;
        n_drive   = r_drive;
        n_freq    = r_freq;
        n_pulse   = 1'b0;
        if (i_cmd.eval) begin
            // Table entry read back: stop on the end marker or a long note.
            if ((w_tab_ms > r_max_note_ms) ||
                ((w_tab_freq == FREQ_SILENT) && (w_tab_ms == '0))) begin
                n_drive   = DRIVE_LOW;
                n_freq    = '0;
                n_busy    = 1'b0;
                n_playing = 1'b0;
                n_armed   = 1'b0;
            end else begin
                if (w_tab_freq == FREQ_SILENT) begin
                    n_drive = DRIVE_LOW;
                    n_freq  = '0;
                    n_busy  = 1'b0;
                end else if (w_tab_freq == FREQ_DEFAULT) begin
                    n_drive = r_modulate ? DRIVE_TONE : DRIVE_HIGH;
                    n_freq  = r_modulate ? r_default_freq : '0;
                end else begin
                    n_drive = DRIVE_TONE;
                    n_freq  = w_tab_freq;
                end
                n_rem   = w_tab_ms;
                n_armed = 1'b1;
                n_pos   = r_pos + 1'b1;
            end
        end else if (i_cmd.take) begin
            unique case (i_item.mode)
                MODE_TICK: begin
                    if (r_armed) begin
                        n_rem = w_dec;
                        if (w_fires) begin
                            n_armed = 1'b0;
                            // Without a further note to fetch, everything stops.
                            if (!(r_playing && w_pos_ok)) begin
                                n_drive   = DRIVE_LOW;
                                n_freq    = '0;
                                n_busy    = 1'b0;
                                n_playing = 1'b0;
                            end
                        end
                    end
                end
                MODE_PLAY: begin
                    n_pos     = POS_W'(i_item.note_index);
                    n_playing = 1'b1;
                    n_busy    = 1'b1;
                    if (!w_idx_ok) begin
                        n_drive   = DRIVE_LOW;
                        n_freq    = '0;
                        n_busy    = 1'b0;
                        n_playing = 1'b0;
                        n_armed   = 1'b0;
                    end
                end
                MODE_BEEP: begin
                    n_playing = 1'b0;
                    n_busy    = 1'b1;
                    if (i_item.beep_freq == FREQ_SILENT) begin
                        n_drive = r_modulate ? DRIVE_TONE : DRIVE_HIGH;
                        n_freq  = r_modulate ? r_default_freq : '0;
                    end else begin
                        n_drive = DRIVE_TONE;
                        n_freq  = i_item.beep_freq;
                    end
                    n_rem   = i_item.beep_ms;
                    n_armed = 1'b1;
                end
                MODE_STOP: begin
                    n_drive   = DRIVE_LOW;
                    n_freq    = '0;
                    n_busy    = 1'b0;
                    n_playing = 1'b0;
                    n_armed   = 1'b0;
                end
                MODE_CLICK: begin
                    n_pulse = !r_busy && !r_playing;
                end
                default: begin
                    // Table writes and unused codes leave the state alone.
                    n_pulse = 1'b0;
                end
            endcase
        end
    end

    // Result word built from the state after the word is applied.
    always_comb begin
        w_res.drive_kind  = n_drive;
        w_res.tone_freq   = (n_drive == DRIVE_TONE) ? n_freq : '0;
        w_res.busy_res    = n_busy || n_playing;
        w_res.playing     = n_playing;
        w_res.click_pulse = n_pulse;
    end

    assign w_push = i_cmd.eval || (i_cmd.take && !o_status.fetch);
    assign w_pop  = (r_cnt != 2'd0) && i_out_ready;
    assign w_left = r_cnt - {1'b0, w_pop};

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulate     <= 1'b1;
            r_default_freq <= DEFAULT_FREQ_RST;
            r_max_note_ms  <= MAX_NOTE_MS_RST;
            r_rem          <= '0;
            r_pos          <= '0;
            r_armed        <= 1'b0;
            r_busy         <= 1'b0;
            r_playing      <= 1'b0;
            r_drive        <= DRIVE_LOW;
            r_freq         <= '0;
            r_cnt          <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MODULATE:     r_modulate     <= i_cfg_data[0];
                    CFG_DEFAULT_FREQ: r_default_freq <= i_cfg_data;
                    CFG_MAX_NOTE_MS:  r_max_note_ms  <= i_cfg_data;
                    default:          r_modulate     <= r_modulate;
                endcase
            end
            r_rem     <= n_rem;
            r_pos     <= n_pos;
            r_armed   <= n_armed;
            r_busy    <= n_busy;
            r_playing <= n_playing;
            r_drive   <= n_drive;
            r_freq    <= n_freq;
            r_cnt     <= w_left + {1'b0, w_push};
        end
    end

    // Result queue payload.
    always_ff @(posedge i_clk) begin
        if (w_pop && (r_cnt == 2'd2)) begin
            r_slot0 <= r_slot1;
        end
        if (w_push && (w_left == 2'd0)) begin
            r_slot0 <= w_res;
        end
        if (w_push && (w_left == 2'd1)) begin
            r_slot1 <= w_res;
        end
    end

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out       = r_slot0;

endmodule

`default_nettype wire
